@@ src/nmea_gga_field_extractor_top_defines.svh @@
// assertion macros shared by the checker
`ifndef NMEA_GGA_FIELD_EXTRACTOR_TOP_DEFINES_SVH
`define NMEA_GGA_FIELD_EXTRACTOR_TOP_DEFINES_SVH

// implication sampled on clock, quiet during reset
`define NGFE_ASSERT_IMPLY(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("ngfe check failed");

// next-cycle implication sampled on clock, quiet during reset
`define NGFE_ASSERT_NEXT(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("ngfe check failed");

`endif

@@ src/ngfe_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ngfe_pkg;

   localparam logic [7:0] CharDollar = 8'h24;
   localparam logic [7:0] CharComma  = 8'h2C;
   localparam logic [7:0] CharStar   = 8'h2A;
   localparam logic [4:0] CksumField = 5'd15;
   localparam logic [4:0] FieldMax   = 5'd31;
   localparam logic [3:0] OffsetMax  = 4'd15;

   typedef struct packed {
      logic [7:0] char_in;
      logic       first_char;
   } req_type;

   typedef struct packed {
      logic       wr_en;
      logic [5:0] wr_addr;
      logic [7:0] wr_data;
      logic       clr_en;
      logic [3:0] clr_group;
   } rsp_type;

   typedef struct packed {
      logic [5:0] base;
      logic [3:0] size;
      logic [3:0] group;
   } slot_type;

   localparam slot_type SlotNone = '{base: 6'd0, size: 4'd0, group: 4'd0};

   // record layout per field; size zero means the field is not stored
   function automatic slot_type slot_of(input logic [4:0] field);
      slot_type s;
      unique case (field)
         5'd1:    s = '{base: 6'd0,  size: 4'd9,  group: 4'd0};
         5'd2:    s = '{base: 6'd9,  size: 4'd10, group: 4'd1};
         5'd3:    s = '{base: 6'd19, size: 4'd1,  group: 4'd2};
         5'd4:    s = '{base: 6'd20, size: 4'd11, group: 4'd3};
         5'd5:    s = '{base: 6'd31, size: 4'd1,  group: 4'd4};
         5'd6:    s = '{base: 6'd32, size: 4'd1,  group: 4'd5};
         5'd7:    s = '{base: 6'd33, size: 4'd2,  group: 4'd6};
         5'd8:    s = '{base: 6'd35, size: 4'd4,  group: 4'd7};
         5'd9:    s = '{base: 6'd39, size: 4'd6,  group: 4'd8};
         5'd10:   s = '{base: 6'd45, size: 4'd1,  group: 4'd9};
         5'd11:   s = '{base: 6'd46, size: 4'd6,  group: 4'd10};
         5'd12:   s = '{base: 6'd52, size: 4'd1,  group: 4'd11};
         5'd15:   s = '{base: 6'd53, size: 4'd2,  group: 4'd12};
         default: s = SlotNone;
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

@@ src/ngfe_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface ngfe_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;
   logic       first_char;

   modport source (output valid, output char_in, output first_char, input ready);
   modport sink (input valid, input char_in, input first_char, output ready);
endinterface

interface ngfe_rsp_if;
   logic       valid;
   logic       ready;
   logic       wr_en;
   logic [5:0] wr_addr;
   logic [7:0] wr_data;
   logic       clr_en;
   logic [3:0] clr_group;

   modport source (
      output valid, output wr_en, output wr_addr, output wr_data,
      output clr_en, output clr_group, input ready
   );
   modport sink (
      input valid, input wr_en, input wr_addr, input wr_data,
      input clr_en, input clr_group, output ready
   );
endinterface

`default_nettype wire

@@ src/nmea_gga_field_extractor_top.sv @@
// channel   | role   | payload
// req_ch    | sink   | char_in[7:0], first_char
// rsp_ch    | source | wr_en, wr_addr[5:0], wr_data[7:0], clr_en, clr_group[3:0]
//
// one item per cycle sustained while rsp_ch is ready; each item passes from acceptance to result
// through the input register and then the result register
// field and offset counters update as an item moves into the result register
// synchronous reset clears valid flags and counters; payload registers are not reset
// a stalled result holds; the input register keeps taking items until it is full
`timescale 1ns / 1ps
`default_nettype none

module nmea_gga_field_extractor_top (
   input  wire logic clock,
   input  wire logic reset,
   ngfe_req_if.sink  req_ch,
   ngfe_rsp_if.source rsp_ch
);
   import ngfe_pkg::*;

   req_type in_item, hold_item;
   rsp_type result, out_item;
   logic    hold_valid, take;

   assign in_item = '{char_in: req_ch.char_in, first_char: req_ch.first_char};

   ngfe_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_ch.valid),
      .in_item    (in_item),
      .in_ready   (req_ch.ready),
      .take       (take),
      .hold_valid (hold_valid),
      .hold_item  (hold_item)
   );

   ngfe_core u_core (
      .clock  (clock),
      .reset  (reset),
      .take   (take),
      .item   (hold_item),
      .result (result)
   );

   ngfe_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (hold_valid),
      .in_item   (result),
      .take      (take),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_item  (out_item)
   );

   assign rsp_ch.wr_en     = out_item.wr_en;
   assign rsp_ch.wr_addr   = out_item.wr_addr;
   assign rsp_ch.wr_data   = out_item.wr_data;
   assign rsp_ch.clr_en    = out_item.clr_en;
   assign rsp_ch.clr_group = out_item.clr_group;
endmodule

`default_nettype wire

@@ src/ngfe_in_reg.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ngfe_in_reg (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   input  wire ngfe_pkg::req_type in_item,
   output logic                 in_ready,
   input  wire logic            take,
   output logic                 hold_valid,
   output ngfe_pkg::req_type    hold_item
);
   import ngfe_pkg::*;

   logic    valid_ff;
   req_type item_ff;

   // free slot, or the held item leaves this cycle
   assign in_ready   = !valid_ff || take;
   assign hold_valid = valid_ff;
   assign hold_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= in_item;
      end
   end
endmodule

`default_nettype wire

@@ src/ngfe_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ngfe_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              take,
   input  wire ngfe_pkg::req_type item,
   output ngfe_pkg::rsp_type      result
);
   import ngfe_pkg::*;

   logic [4:0] field_number_ff, field_number_in;
   logic [3:0] field_offset_ff, field_offset_in;
   logic [4:0] fn_cur;
   logic [3:0] fo_cur, fo_inc;
   slot_type   slot;

   always_comb begin
      fn_cur = item.first_char ? 5'd0 : field_number_ff;
      fo_cur = item.first_char ? 4'd0 : field_offset_ff;
      slot   = slot_of(fn_cur);
      fo_inc = (fo_cur == OffsetMax) ? fo_cur : fo_cur + 4'd1;

      result          = '0;
      field_number_in = fn_cur;
      field_offset_in = fo_cur;

      priority if (item.char_in == CharDollar) begin
         field_number_in = 5'd0;
         field_offset_in = 4'd0;
      end else if (item.char_in == CharComma) begin
         // empty field clears its group
         if (fo_cur == 4'd0 && slot.size != 4'd0) begin
            result.clr_en    = 1'b1;
            result.clr_group = slot.group;
         end
         field_number_in = (fn_cur == FieldMax) ? fn_cur : fn_cur + 5'd1;
         field_offset_in = 4'd0;
      end else if (item.char_in == CharStar) begin
         field_number_in = CksumField;
         field_offset_in = 4'd0;
      end else begin
         field_offset_in = fo_inc;
         if (fo_inc <= slot.size) begin
            result.wr_en   = 1'b1;
            result.wr_addr = slot.base + {2'b00, fo_inc} - 6'd1;
            result.wr_data = item.char_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         field_number_ff <= 5'd0;
         field_offset_ff <= 4'd0;
      end else if (take) begin
         field_number_ff <= field_number_in;
         field_offset_ff <= field_offset_in;
      end
   end
endmodule

`default_nettype wire

@@ src/ngfe_out_reg.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ngfe_out_reg (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire ngfe_pkg::rsp_type in_item,
   output logic                   take,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output ngfe_pkg::rsp_type      out_item
);
   import ngfe_pkg::*;

   logic    valid_ff;
   rsp_type item_ff;

   assign take      = in_valid && (!valid_ff || out_ready);
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!valid_ff || out_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= in_item;
      end
   end
endmodule

`default_nettype wire

@@ src/ngfe_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "nmea_gga_field_extractor_top_defines.svh"

module ngfe_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       wr_en,
   input wire logic [5:0] wr_addr,
   input wire logic [7:0] wr_data,
   input wire logic       clr_en,
   input wire logic [3:0] clr_group
);
   import ngfe_pkg::*;

   logic [19:0] payload;
   logic        write_legal;
   logic        idle_legal;

   assign payload     = {wr_en, wr_addr, wr_data, clr_en, clr_group};
   assign write_legal = (wr_addr <= 6'd54) && (wr_data != CharDollar) &&
                        (wr_data != CharComma) && (wr_data != CharStar);
   assign idle_legal  = (wr_addr == 6'd0) && (wr_data == 8'd0) &&
                        (clr_en ? (clr_group <= 4'd12) : (clr_group == 4'd0));

   // a stalled item keeps its payload
   `NGFE_ASSERT_NEXT(a_stall_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(payload))

   // one item never both writes and clears
   `NGFE_ASSERT_IMPLY(a_one_action, rsp_valid, !(wr_en && clr_en))

   // delimiters are never stored, and writes stay inside the record
   `NGFE_ASSERT_IMPLY(a_write_ok, rsp_valid && wr_en, write_legal)

   // idle results carry zeros, clears name a real group
   `NGFE_ASSERT_IMPLY(a_clear_ok, rsp_valid && !wr_en, idle_legal)
endmodule

bind nmea_gga_field_extractor_top ngfe_checker u_ngfe_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .wr_en     (rsp_ch.wr_en),
   .wr_addr   (rsp_ch.wr_addr),
   .wr_data   (rsp_ch.wr_data),
   .clr_en    (rsp_ch.clr_en),
   .clr_group (rsp_ch.clr_group)
);

`default_nettype wire
